// File: rtl/core/ocb_pkg.sv
// Package for the OCB3 AES-128 encryption block.
// Holds the channel structs, codes and AES, doubling and byte-mask helpers.
// No dependencies.
package ocb_pkg;

    localparam int NONCE_BYTES = 12;
    localparam int TAG_BYTES   = 16;
    localparam int MAX_BLOCKS  = 4096;
    localparam int BLKNUM_W    = 13;

    localparam logic [0:0] REG_KEY_HIGH = 1'b0;
    localparam logic [0:0] REG_KEY_LOW  = 1'b1;
    localparam int         CFG_IDX_W    = 2;

    localparam logic [7:0] DBL_POLY   = 8'd135;
    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam logic [7:0] BOTTOM_MSK = 8'h3F;
    localparam logic [7:0] TOP_MSK    = 8'hC0;
    localparam logic [7:0] NONCE_ONE  = 8'h01;

    typedef struct packed {
        logic [31:0] seqno;
        logic [63:0] data_high;
        logic [63:0] data_low;
        logic [4:0]  valid_bytes;
        logic        last_block;
    } in_t;

    typedef struct packed {
        logic [63:0] out_high;
        logic [63:0] out_low;
        logic [4:0]  out_bytes;
        logic        is_tag;
        logic        last;
    } out_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [127:0] key_step(input logic [127:0] rk, input logic [7:0] rcon);
        logic [31:0] w0, w1, w2, w3, k;
        w0 = rk[127:96];
        w1 = rk[95:64];
        w2 = rk[63:32];
        w3 = rk[31:0];
        k = {SBOX[w3[23:16]] ^ rcon, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
        w0 = w0 ^ k;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        return {w0, w1, w2, w3};
    endfunction

    function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] rk,
                                               input logic final_rnd);
        logic [7:0] t [16];
        logic [7:0] a, q0, q1, q2, q3;
        logic [127:0] res;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[r + 4 * c] = SBOX[s[127 - 8 * (r + 4 * ((c + r) % 4)) -: 8]];
            end
        end
        if (!final_rnd) begin
            for (int c = 0; c < 4; c++) begin
                q0 = t[4 * c];
                q1 = t[4 * c + 1];
                q2 = t[4 * c + 2];
                q3 = t[4 * c + 3];
                a = q0 ^ q1 ^ q2 ^ q3;
                t[4 * c]     = q0 ^ a ^ xtime(q0 ^ q1);
                t[4 * c + 1] = q1 ^ a ^ xtime(q1 ^ q2);
                t[4 * c + 2] = q2 ^ a ^ xtime(q2 ^ q3);
                t[4 * c + 3] = q3 ^ a ^ xtime(q3 ^ q0);
            end
        end
        for (int i = 0; i < 16; i++) begin
            res[127 - 8 * i -: 8] = t[i];
        end
        return res ^ rk;
    endfunction

    function automatic logic [127:0] dbl(input logic [127:0] v);
        return {v[126:0], 1'b0} ^ {120'd0, (v[127] ? DBL_POLY : 8'h00)};
    endfunction

    function automatic logic [127:0] byte_mask(input logic [4:0] n);
        logic [127:0] m;
        for (int i = 0; i < 16; i++) begin
            m[127 - 8 * i -: 8] = (5'(i) < n) ? 8'hff : 8'h00;
        end
        return m;
    endfunction

    function automatic logic [127:0] pad_bit(input logic [4:0] n);
        logic [127:0] m;
        for (int i = 0; i < 16; i++) begin
            m[127 - 8 * i -: 8] = (5'(i) == n) ? PAD_BYTE : 8'h00;
        end
        return m;
    endfunction

endpackage

// File: rtl/core/ocb_aes_core.sv
// Iterative AES-128 encryption unit, one round per cycle with the key
// schedule computed on the fly. Depends on ocb_pkg.
module ocb_aes_core (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [127:0] din,
    input  logic [127:0] key,
    output logic         busy,
    output logic [127:0] dout
);
    import ocb_pkg::*;

    localparam logic [3:0] LAST_RND = 4'd10;

    logic         busy_reg, busy_next;
    logic [3:0]   rnd_reg, rnd_next;
    logic [7:0]   rcon_reg, rcon_next;
    logic [127:0] st_reg, st_next;
    logic [127:0] rk_reg, rk_next;

    always_comb begin
        busy_next = busy_reg;
        rnd_next  = rnd_reg;
        rcon_next = rcon_reg;
        st_next   = st_reg;
        rk_next   = rk_reg;
        if (start) begin
            busy_next = 1'b1;
            rnd_next  = 4'd1;
            rcon_next = 8'h01;
            st_next   = din ^ key;
            rk_next   = key;
        end else if (busy_reg) begin
            rk_next   = key_step(rk_reg, rcon_reg);
            st_next   = aes_round(st_reg, rk_next, rnd_reg == LAST_RND);
            rcon_next = xtime(rcon_reg);
            rnd_next  = rnd_reg + 4'd1;
            busy_next = (rnd_reg != LAST_RND);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
        rnd_reg  <= rnd_next;
        rcon_reg <= rcon_next;
        st_reg   <= st_next;
        rk_reg   <= rk_next;
    end

    assign busy = busy_reg;
    assign dout = st_reg;

endmodule

// File: rtl/core/ocb3_aes128_encrypt.sv
// OCB3 encryption with AES-128, one 16-byte block per transaction.
// Each AES pass runs in the shared round unit, an initial key addition and ten rounds. A full
// block's L value is doubled once per trailing zero of its index before its AES pass,
// a message's first block adds two AES passes (L* and the nonce), and a last block adds one for the tag.
// One transaction is in flight at a time. Reset (aresetn low, synchronous)
// clears the key, the message state and the result valid flag.
module ocb3_aes128_encrypt (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ocb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                   cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  ocb_pkg::in_t                  s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output ocb_pkg::out_t                 m_data
);
    import ocb_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_LSTAR = 4'd1;
    localparam logic [3:0] ST_KTOP  = 4'd2;
    localparam logic [3:0] ST_DISP  = 4'd3;
    localparam logic [3:0] ST_DBL   = 4'd4;
    localparam logic [3:0] ST_FULL  = 4'd5;
    localparam logic [3:0] ST_PART  = 4'd6;
    localparam logic [3:0] ST_TAGGO = 4'd7;
    localparam logic [3:0] ST_TAG   = 4'd8;

    logic [3:0]          state_reg, state_next;
    logic [63:0]         keyh_reg, keyh_next, keyl_reg, keyl_next;
    logic [127:0]        lstar_reg, lstar_next, ldol_reg, ldol_next;
    logic [127:0]        off_reg, off_next, sum_reg, sum_next;
    logic [127:0]        l_reg, l_next;
    logic [BLKNUM_W-1:0] bn_reg, bn_next, idx_reg, idx_next;
    logic                inmsg_reg, inmsg_next;
    in_t                 in_reg, in_next;
    logic                mv_reg, mv_next;
    out_t                out_reg, out_next;

    logic         aes_start, aes_busy;
    logic [127:0] aes_din, aes_dout;
    logic [4:0]   vb;
    logic         full_blk, out_free;
    logic [127:0] ptext, nonce, ppad, cres, offs0;
    logic [191:0] stretch;
    logic [5:0]   bottom;

    ocb_aes_core u_aes (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (aes_start),
        .din    (aes_din),
        .key    ({keyh_reg, keyl_reg}),
        .busy   (aes_busy),
        .dout   (aes_dout)
    );

    always_comb begin
        nonce = '0;
        for (int i = 0; i < 4 && i < NONCE_BYTES; i++) begin
            nonce[127 - 8 * (16 - NONCE_BYTES + i) -: 8] = in_reg.seqno[8 * i +: 8];
        end
        nonce[127 -: 8] = 8'(((TAG_BYTES * 8) % 128) << 1);
        nonce[127 - 8 * (15 - NONCE_BYTES) -: 8] =
            nonce[127 - 8 * (15 - NONCE_BYTES) -: 8] | NONCE_ONE;
        bottom = 6'(nonce[7:0] & BOTTOM_MSK);
        nonce[7:0] = nonce[7:0] & TOP_MSK;
    end

    assign stretch = {aes_dout, aes_dout[127:64] ^ aes_dout[119:56]};
    assign offs0   = 128'((stretch << bottom) >> 64);

    assign vb        = (in_reg.valid_bytes > 5'd16) ? 5'd16 : in_reg.valid_bytes;
    assign full_blk  = !in_reg.last_block || (vb == 5'd16);
    assign ptext     = {in_reg.data_high, in_reg.data_low};
    assign ppad      = (ptext & byte_mask(vb)) | pad_bit(vb);
    assign cres      = (ppad ^ aes_dout) & byte_mask(vb);
    assign out_free  = !mv_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    always_comb begin
        state_next = state_reg;
        keyh_next  = keyh_reg;
        keyl_next  = keyl_reg;
        lstar_next = lstar_reg;
        ldol_next  = ldol_reg;
        off_next   = off_reg;
        sum_next   = sum_reg;
        l_next     = l_reg;
        bn_next    = bn_reg;
        idx_next   = idx_reg;
        inmsg_next = inmsg_reg;
        in_next    = in_reg;
        mv_next    = mv_reg && !m_ready;
        out_next   = out_reg;
        aes_start  = 1'b0;
        aes_din    = '0;

        if (cfg_valid) begin
            case (cfg_index)
                CFG_IDX_W'(REG_KEY_HIGH): keyh_next = cfg_data;
                CFG_IDX_W'(REG_KEY_LOW):  keyl_next = cfg_data;
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    in_next = s_data;
                    if (!inmsg_reg) begin
                        aes_start  = 1'b1;
                        state_next = ST_LSTAR;
                    end else begin
                        state_next = ST_DISP;
                    end
                end
            end
            ST_LSTAR: begin
                if (!aes_busy) begin
                    lstar_next = aes_dout;
                    ldol_next  = dbl(aes_dout);
                    aes_start  = 1'b1;
                    aes_din    = nonce;
                    state_next = ST_KTOP;
                end
            end
            ST_KTOP: begin
                if (!aes_busy) begin
                    off_next   = offs0;
                    sum_next   = '0;
                    bn_next    = '0;
                    inmsg_next = 1'b1;
                    state_next = ST_DISP;
                end
            end
            ST_DISP: begin
                if (full_blk) begin
                    l_next     = dbl(ldol_reg);
                    idx_next   = bn_reg + BLKNUM_W'(1);
                    state_next = ST_DBL;
                end else if (vb != 5'd0) begin
                    off_next   = off_reg ^ lstar_reg;
                    aes_start  = 1'b1;
                    aes_din    = off_reg ^ lstar_reg;
                    state_next = ST_PART;
                end else begin
                    state_next = ST_TAGGO;
                end
            end
            ST_DBL: begin
                if (!idx_reg[0]) begin
                    l_next   = dbl(l_reg);
                    idx_next = idx_reg >> 1;
                end else begin
                    off_next   = off_reg ^ l_reg;
                    aes_start  = 1'b1;
                    aes_din    = ptext ^ off_reg ^ l_reg;
                    state_next = ST_FULL;
                end
            end
            ST_FULL: begin
                if (!aes_busy && out_free) begin
                    mv_next  = 1'b1;
                    {out_next.out_high, out_next.out_low} = aes_dout ^ off_reg;
                    out_next.out_bytes = 5'd16;
                    out_next.is_tag    = 1'b0;
                    out_next.last      = 1'b0;
                    sum_next = sum_reg ^ ptext;
                    if (bn_reg < BLKNUM_W'(MAX_BLOCKS - 1)) begin
                        bn_next = bn_reg + BLKNUM_W'(1);
                    end
                    state_next = in_reg.last_block ? ST_TAGGO : ST_IDLE;
                end
            end
            ST_PART: begin
                if (!aes_busy && out_free) begin
                    mv_next  = 1'b1;
                    {out_next.out_high, out_next.out_low} = cres;
                    out_next.out_bytes = vb;
                    out_next.is_tag    = 1'b0;
                    out_next.last      = 1'b0;
                    sum_next   = sum_reg ^ ppad;
                    state_next = ST_TAGGO;
                end
            end
            ST_TAGGO: begin
                aes_start  = 1'b1;
                aes_din    = sum_reg ^ off_reg ^ ldol_reg;
                state_next = ST_TAG;
            end
            ST_TAG: begin
                if (!aes_busy && out_free) begin
                    mv_next  = 1'b1;
                    {out_next.out_high, out_next.out_low} = aes_dout & byte_mask(5'(TAG_BYTES));
                    out_next.out_bytes = 5'(TAG_BYTES);
                    out_next.is_tag    = 1'b1;
                    out_next.last      = 1'b1;
                    inmsg_next = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            keyh_reg  <= '0;
            keyl_reg  <= '0;
            lstar_reg <= '0;
            ldol_reg  <= '0;
            off_reg   <= '0;
            sum_reg   <= '0;
            bn_reg    <= '0;
            inmsg_reg <= 1'b0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            keyh_reg  <= keyh_next;
            keyl_reg  <= keyl_next;
            lstar_reg <= lstar_next;
            ldol_reg  <= ldol_next;
            off_reg   <= off_next;
            sum_reg   <= sum_next;
            bn_reg    <= bn_next;
            inmsg_reg <= inmsg_next;
            mv_reg    <= mv_next;
        end
        l_reg   <= l_next;
        idx_reg <= idx_next;
        in_reg  <= in_next;
        out_reg <= out_next;
    end

    assign m_valid = mv_reg;
    assign m_data  = out_reg;

endmodule

// File: rtl/core/ocb_checker.sv
// Port-level checks for the OCB3 AES-128 encryption block, with its bind.
// Depends on ocb_pkg and ocb3_aes128_encrypt.
module ocb_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_valid,
    input logic          s_ready,
    input logic          m_valid,
    input logic          m_ready,
    input ocb_pkg::out_t m_data
);
    import ocb_pkg::*;

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("a second transaction was accepted while one is in flight");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("a stalled result changed");

    a_tag_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.is_tag == m_data.last))
        else $error("tag and last flags disagree");

    a_tag_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.is_tag |-> m_data.out_bytes == 5'(TAG_BYTES))
        else $error("tag has the wrong length");

    a_ct_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.is_tag |-> m_data.out_bytes != 5'd0 && m_data.out_bytes <= 5'd16)
        else $error("ciphertext length out of range");

endmodule

bind ocb3_aes128_encrypt ocb_checker u_ocb_checker (
    .aclk   (aclk),
    .aresetn(aresetn),
    .s_valid(s_valid),
    .s_ready(s_ready),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_data (m_data)
);
